FILE: hdl/hbfd_pkg.sv
package hbfd_pkg;

	localparam int unsigned MaxLineDefault = 8192;
	localparam int unsigned MaxHexDigitsDefault = 16;

	localparam logic [1:0] CMD_DATA    = 2'd0;
	localparam logic [1:0] CMD_CLOSE   = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_SPARE   = 2'd3;

	localparam logic [1:0] MODE_FIXED   = 2'd0;
	localparam logic [1:0] MODE_CHUNKED = 2'd1;
	localparam logic [1:0] MODE_SPARE   = 2'd3;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_SYNTAX = 2'd1;
	localparam logic [1:0] ERR_LINE   = 2'd2;
	localparam logic [1:0] ERR_AFTER  = 2'd3;

	localparam logic [0:0] REG_MODE   = 1'd0;
	localparam logic [0:0] REG_LENGTH = 1'd1;

	typedef enum logic [7:0] {
		PH_FIXED   = 8'b0000_0001,
		PH_EOF     = 8'b0000_0010,
		PH_SIZE    = 8'b0000_0100,
		PH_DATA    = 8'b0000_1000,
		PH_DATA_CR = 8'b0001_0000,
		PH_DATA_LF = 8'b0010_0000,
		PH_TRAILER = 8'b0100_0000,
		PH_DONE    = 8'b1000_0000
	} phase_t;

	typedef enum logic [11:0] {
		X_LEAD       = 12'b0000_0000_0001,
		X_DIGITS     = 12'b0000_0000_0010,
		X_TRAIL      = 12'b0000_0000_0100,
		X_NAME_START = 12'b0000_0000_1000,
		X_NAME       = 12'b0000_0001_0000,
		X_AFTER_NAME = 12'b0000_0010_0000,
		X_VAL_START  = 12'b0000_0100_0000,
		X_VAL_TOKEN  = 12'b0000_1000_0000,
		X_QUOTED     = 12'b0001_0000_0000,
		X_ESCAPE     = 12'b0010_0000_0000,
		X_AFTER_VAL  = 12'b0100_0000_0000,
		X_BAD        = 12'b1000_0000_0000
	} ext_t;

	typedef struct packed {
		logic is_ws;
		logic is_token;
		logic is_quoted;
		logic is_hex;
		logic [3:0] hex_val;
	} char_class_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t r;
		r.is_ws = (c == 8'h20) || (c == 8'h09);
		r.is_token = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || c == "!" || c == "#" || c == "$" ||
			c == "%" || c == "&" || c == 8'h27 || c == "*" || c == "+" ||
			c == "-" || c == "." || c == "^" || c == "_" || c == 8'h60 ||
			c == "|" || c == "~";
		r.is_quoted = c == 8'h09 || c == 8'h20 || c == 8'h21 ||
			(c >= 8'h23 && c <= 8'h5B) || (c >= 8'h5D && c <= 8'h7E) || c >= 8'h80;
		r.is_hex = 1'b1;
		r.hex_val = 4'd0;
		if (c >= "0" && c <= "9") r.hex_val = 4'(c - "0");
		else if (c >= "a" && c <= "f") r.hex_val = 4'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") r.hex_val = 4'(c - "A" + 8'd10);
		else r.is_hex = 1'b0;
		return r;
	endfunction

endpackage

FILE: hdl/hbfd_ext_fsm.sv
module hbfd_ext_fsm
	import hbfd_pkg::*;
(
	input  ext_t       cur,
	input  logic [7:0] c,
	output ext_t       nxt
);
	char_class_t k;
	logic semi, eq, dq, bs;

	always_comb begin
		k = classify(c);
		semi = c == ";";
		eq = c == "=";
		dq = c == 8'h22;
		bs = c == 8'h5C;
		nxt = X_BAD;
		unique case (cur)
			X_LEAD: begin
				if (k.is_ws) nxt = X_LEAD;
				else if (k.is_hex) nxt = X_DIGITS;
			end
			X_DIGITS: begin
				if (k.is_hex) nxt = X_DIGITS;
				else if (k.is_ws) nxt = X_TRAIL;
				else if (semi) nxt = X_NAME_START;
			end
			X_TRAIL: begin
				if (k.is_ws) nxt = X_TRAIL;
				else if (semi) nxt = X_NAME_START;
			end
			X_NAME_START: begin
				if (k.is_ws) nxt = X_NAME_START;
				else if (k.is_token) nxt = X_NAME;
			end
			X_NAME: begin
				if (k.is_token) nxt = X_NAME;
				else if (k.is_ws) nxt = X_AFTER_NAME;
				else if (eq) nxt = X_VAL_START;
				else if (semi) nxt = X_NAME_START;
			end
			X_AFTER_NAME: begin
				if (k.is_ws) nxt = X_AFTER_NAME;
				else if (eq) nxt = X_VAL_START;
				else if (semi) nxt = X_NAME_START;
			end
			X_VAL_START: begin
				if (k.is_ws) nxt = X_VAL_START;
				else if (dq) nxt = X_QUOTED;
				else if (k.is_token) nxt = X_VAL_TOKEN;
			end
			X_VAL_TOKEN: begin
				if (k.is_token) nxt = X_VAL_TOKEN;
				else if (k.is_ws) nxt = X_AFTER_VAL;
				else if (semi) nxt = X_NAME_START;
			end
			X_QUOTED: begin
				if (dq) nxt = X_AFTER_VAL;
				else if (bs) nxt = X_ESCAPE;
				else if (k.is_quoted) nxt = X_QUOTED;
			end
			X_ESCAPE: begin
				if (c == 8'h09 || (c >= 8'h20 && c != 8'h7F)) nxt = X_QUOTED;
			end
			X_AFTER_VAL: begin
				if (k.is_ws) nxt = X_AFTER_VAL;
				else if (semi) nxt = X_NAME_START;
			end
			default: nxt = X_BAD;
		endcase
	end
endmodule

FILE: hdl/http_body_framing_decoder.sv
// a result word is registered and appears in the cycle after its input word is accepted
// throughput: one word per cycle unless a full output is stalled, one update per byte
// the output register holds one word; input is taken while it is empty or being taken
// reset (arst_n low, asynchronous) clears all but the result fields, selects fixed
// mode with length 0 so the body reads as complete and no error is latched
module http_body_framing_decoder
	import hbfd_pkg::*;
#(
	parameter int unsigned MAX_LINE = MaxLineDefault,
	parameter int unsigned MAX_HEX_DIGITS = MaxHexDigitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        body_valid,
	output logic [7:0]  body_byte,
	output logic        message_done,
	output logic [1:0]  err_status,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	localparam int LW = $clog2(MAX_LINE + 2);
	localparam int DW = $clog2(MAX_HEX_DIGITS + 2);
	localparam logic [LW-1:0] LMAX = LW'(MAX_LINE);
	localparam logic [DW-1:0] DMAX = DW'(MAX_HEX_DIGITS);

	logic [1:0]    mode_q;
	logic [63:0]   len_q;
	phase_t        phase_q, phase_d;
	logic [63:0]   rem_q, rem_d, acc_q, acc_d, cnt_q, cnt_d;
	logic [DW-1:0] dig_q, dig_d;
	logic [LW-1:0] line_q, line_d;
	ext_t          ext_q, ext_d, ext_nxt;
	logic          cr_q, cr_d, col_q, col_d;
	logic [1:0]    err_q, err_d;
	logic          vld_d;
	logic          take;
	char_class_t   k;

	assign in_stall = out_valid && out_stall;
	assign take = in_valid && !in_stall;

	hbfd_ext_fsm u_ext (.cur(ext_q), .c(data_byte), .nxt(ext_nxt));

	always_comb begin
		logic [LW-1:0] lb;
		logic ok;
		k = classify(data_byte);
		phase_d = phase_q; rem_d = rem_q; acc_d = acc_q; cnt_d = cnt_q;
		dig_d = dig_q; line_d = line_q; ext_d = ext_q; cr_d = cr_q;
		col_d = col_q; err_d = err_q; vld_d = 1'b0;
		lb = (line_q <= LMAX) ? line_q + 1'b1 : line_q;
		ok = 1'b0;
		if (cmd == CMD_RESTART) begin
			rem_d = '0; cnt_d = '0; err_d = ERR_NONE;
			acc_d = '0; dig_d = '0; line_d = '0; ext_d = X_LEAD; cr_d = 1'b0; col_d = 1'b0;
			if (mode_q == MODE_FIXED) phase_d = (len_q == 64'd0) ? PH_DONE : PH_FIXED;
			else if (mode_q == MODE_CHUNKED) phase_d = PH_SIZE;
			else phase_d = PH_EOF;
		end else if (cmd == CMD_CLOSE) begin
			if (err_q == ERR_NONE && phase_q == PH_EOF) phase_d = PH_DONE;
		end else if (cmd == CMD_DATA && err_q == ERR_NONE) begin
			unique case (phase_q)
				PH_FIXED: begin
					vld_d = 1'b1;
					cnt_d = cnt_q + 64'd1;
					if (cnt_d >= len_q) phase_d = PH_DONE;
				end
				PH_EOF: vld_d = 1'b1;
				PH_SIZE: begin
					if (cr_q && data_byte == 8'h0A) begin
						ok = ext_q == X_DIGITS || ext_q == X_TRAIL || ext_q == X_NAME ||
							ext_q == X_AFTER_NAME || ext_q == X_VAL_TOKEN ||
							ext_q == X_AFTER_VAL;
						if (!ok || dig_q > DMAX) err_d = ERR_SYNTAX;
						else begin
							rem_d = acc_q;
							phase_d = (acc_q == 64'd0) ? PH_TRAILER : PH_DATA;
							acc_d = '0; dig_d = '0; line_d = '0; ext_d = X_LEAD;
							cr_d = 1'b0; col_d = 1'b0;
						end
					end else begin
						if (cr_q) ext_d = X_BAD;
						cr_d = data_byte == 8'h0D;
						line_d = lb;
						if (lb > LMAX) err_d = ERR_LINE;
						else if (!cr_d) begin
							ext_d = cr_q ? X_BAD : ext_nxt;
							if (!cr_q && (ext_q == X_LEAD || ext_q == X_DIGITS) && k.is_hex
								&& dig_q <= DMAX) begin
								dig_d = dig_q + 1'b1;
								acc_d = {acc_q[59:0], k.hex_val};
							end
						end
					end
				end
				PH_DATA: begin
					vld_d = 1'b1;
					rem_d = (rem_q != 64'd0) ? rem_q - 64'd1 : rem_q;
					if (rem_d == 64'd0) phase_d = PH_DATA_CR;
				end
				PH_DATA_CR: begin
					if (data_byte == 8'h0D) phase_d = PH_DATA_LF;
					else err_d = ERR_SYNTAX;
				end
				PH_DATA_LF: begin
					if (data_byte == 8'h0A) begin
						phase_d = PH_SIZE;
						acc_d = '0; dig_d = '0; line_d = '0; ext_d = X_LEAD;
						cr_d = 1'b0; col_d = 1'b0;
					end else err_d = ERR_SYNTAX;
				end
				PH_TRAILER: begin
					if (cr_q && data_byte == 8'h0A) begin
						if (line_q == LW'(1)) phase_d = PH_DONE;
						else if (!col_q) err_d = ERR_SYNTAX;
						acc_d = '0; dig_d = '0; line_d = '0; ext_d = X_LEAD;
						cr_d = 1'b0; col_d = 1'b0;
					end else begin
						cr_d = data_byte == 8'h0D;
						line_d = lb;
						if (lb > LMAX) err_d = ERR_LINE;
						else if (data_byte == ":") col_d = 1'b1;
					end
				end
				PH_DONE: err_d = ERR_AFTER;
				default: err_d = ERR_AFTER;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; len_q <= '0; phase_q <= PH_DONE;
			rem_q <= '0; acc_q <= '0; cnt_q <= '0; dig_q <= '0; line_q <= '0;
			ext_q <= X_LEAD; cr_q <= 1'b0; col_q <= 1'b0; err_q <= ERR_NONE;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE:   mode_q <= cfg_data[1:0];
					REG_LENGTH: len_q <= cfg_data;
					default: ;
				endcase
			end
			if (take) begin
				phase_q <= phase_d; rem_q <= rem_d; acc_q <= acc_d; cnt_q <= cnt_d;
				dig_q <= dig_d; line_q <= line_d; ext_q <= ext_d; cr_q <= cr_d;
				col_q <= col_d; err_q <= err_d;
				out_valid <= 1'b1;
			end else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			body_valid <= vld_d;
			body_byte <= vld_d ? data_byte : 8'd0;
			message_done <= phase_d == PH_DONE;
			err_status <= err_d;
		end
	end
endmodule

FILE: hdl/hbfd_checker.sv
module hbfd_checker
	import hbfd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] cmd,
	input logic       out_valid,
	input logic       out_stall,
	input logic       body_valid,
	input logic [7:0] body_byte,
	input logic [1:0] err_status
);
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid) else $error("accepted word gave no result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(body_byte))
		else $error("stalled result changed");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall) else $error("stall without full output");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_RESTART |=> err_status == ERR_NONE && !body_valid)
		else $error("restart left error or payload");
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && err_status != ERR_NONE |-> !body_valid) else $error("payload during error");
endmodule

bind http_body_framing_decoder hbfd_checker u_chk (.*);

FILE: test/tb_http_body_framing_decoder.sv
`timescale 1ns / 1ps

module tb_http_body_framing_decoder;
	import hbfd_pkg::*;

	localparam int unsigned LINE_MAX = 8192;
	localparam int unsigned DIGITS_MAX = 16;
	localparam int unsigned WATCHDOG = 20000;

	typedef enum logic [3:0] {
		S_FIXED, S_EOF, S_SIZE, S_DATA, S_DATA_CR, S_DATA_LF, S_TRAILER, S_DONE
	} body_state_t;

	typedef enum logic [3:0] {
		E_LEAD, E_DIGITS, E_TRAIL, E_NAME_START, E_NAME, E_AFTER_NAME, E_VAL_START,
		E_VAL_TOKEN, E_QUOTED, E_ESCAPE, E_AFTER_VAL, E_BAD
	} size_state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data;
	} in_word_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] payload;
		logic       done;
		logic [1:0] err;
	} out_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_DATA;
	logic [7:0]  data_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        body_valid;
	logic [7:0]  body_byte;
	logic        message_done;
	logic [1:0]  err_status;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_MODE;
	logic [63:0] cfg_data = 64'd0;

	http_body_framing_decoder dut (.*);

	always #1 clk = ~clk;

	// predictor state
	logic [1:0]  m_mode;
	logic [63:0] m_length;
	body_state_t st;
	size_state_t xs;
	logic [63:0] remaining, accum, count;
	int unsigned ndigits, linelen;
	logic        crp, colon;
	logic [1:0]  err;

	in_word_t  pending[$];
	out_word_t expected_words[$];
	int        failures = 0;
	bit        quiet = 1'b0;
	bit        in_taken = 1'b0;
	int        in_gap = 0, out_gap = 0, idle_cycles = 0;

	function automatic bit ws(logic [7:0] c);
		return c == 8'h20 || c == 8'h09;
	endfunction

	function automatic bit tok(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
			c == "!" || c == "#" || c == "$" || c == "%" || c == "&" || c == 8'h27 ||
			c == "*" || c == "+" || c == "-" || c == "." || c == "^" || c == "_" ||
			c == 8'h60 || c == "|" || c == "~";
	endfunction

	function automatic bit qch(logic [7:0] c);
		return c == 8'h09 || c == 8'h20 || c == 8'h21 || (c >= 8'h23 && c <= 8'h5B) ||
			(c >= 8'h5D && c <= 8'h7E) || c >= 8'h80;
	endfunction

	function automatic int hexv(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic void clear_line();
		accum = 0;
		ndigits = 0;
		linelen = 0;
		xs = E_LEAD;
		crp = 1'b0;
		colon = 1'b0;
	endfunction

	function automatic void start_body();
		remaining = 0;
		count = 0;
		err = ERR_NONE;
		clear_line();
		if (m_mode == MODE_FIXED) st = (m_length == 0) ? S_DONE : S_FIXED;
		else if (m_mode == MODE_CHUNKED) st = S_SIZE;
		else st = S_EOF;
	endfunction

	function automatic bit count_line();
		if (linelen <= LINE_MAX) linelen++;
		if (linelen > LINE_MAX) begin
			err = ERR_LINE;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void push_digit(int v);
		if (ndigits <= DIGITS_MAX) begin
			ndigits++;
			accum = (accum << 4) | 64'(v);
		end
	endfunction

	function automatic size_state_t size_next(size_state_t s, logic [7:0] c);
		int v;
		v = hexv(c);
		case (s)
			E_LEAD: begin
				if (ws(c)) return E_LEAD;
				if (v >= 0) begin
					push_digit(v);
					return E_DIGITS;
				end
				return E_BAD;
			end
			E_DIGITS: begin
				if (v >= 0) begin
					push_digit(v);
					return E_DIGITS;
				end
				if (ws(c)) return E_TRAIL;
				if (c == ";") return E_NAME_START;
				return E_BAD;
			end
			E_TRAIL: begin
				if (ws(c)) return E_TRAIL;
				if (c == ";") return E_NAME_START;
				return E_BAD;
			end
			E_NAME_START: begin
				if (ws(c)) return E_NAME_START;
				if (tok(c)) return E_NAME;
				return E_BAD;
			end
			E_NAME: begin
				if (tok(c)) return E_NAME;
				if (ws(c)) return E_AFTER_NAME;
				if (c == "=") return E_VAL_START;
				if (c == ";") return E_NAME_START;
				return E_BAD;
			end
			E_AFTER_NAME: begin
				if (ws(c)) return E_AFTER_NAME;
				if (c == "=") return E_VAL_START;
				if (c == ";") return E_NAME_START;
				return E_BAD;
			end
			E_VAL_START: begin
				if (ws(c)) return E_VAL_START;
				if (c == 8'h22) return E_QUOTED;
				if (tok(c)) return E_VAL_TOKEN;
				return E_BAD;
			end
			E_VAL_TOKEN: begin
				if (tok(c)) return E_VAL_TOKEN;
				if (ws(c)) return E_AFTER_VAL;
				if (c == ";") return E_NAME_START;
				return E_BAD;
			end
			E_QUOTED: begin
				if (c == 8'h22) return E_AFTER_VAL;
				if (c == 8'h5C) return E_ESCAPE;
				if (qch(c)) return E_QUOTED;
				return E_BAD;
			end
			E_ESCAPE: begin
				if (c == 8'h09 || (c >= 8'h20 && c != 8'h7F)) return E_QUOTED;
				return E_BAD;
			end
			E_AFTER_VAL: begin
				if (ws(c)) return E_AFTER_VAL;
				if (c == ";") return E_NAME_START;
				return E_BAD;
			end
			default: return E_BAD;
		endcase
	endfunction

	function automatic void size_byte(logic [7:0] c);
		bit ok;
		if (crp && c == 8'h0A) begin
			ok = xs inside {E_DIGITS, E_TRAIL, E_NAME, E_AFTER_NAME, E_VAL_TOKEN, E_AFTER_VAL};
			if (!ok || ndigits > DIGITS_MAX) begin
				err = ERR_SYNTAX;
				return;
			end
			remaining = accum;
			st = (accum == 0) ? S_TRAILER : S_DATA;
			clear_line();
			return;
		end
		if (crp) xs = E_BAD;
		crp = (c == 8'h0D);
		if (!count_line()) return;
		if (!crp) xs = size_next(xs, c);
	endfunction

	function automatic void trailer_byte(logic [7:0] c);
		if (crp && c == 8'h0A) begin
			if (linelen == 1) st = S_DONE;
			else if (!colon) err = ERR_SYNTAX;
			clear_line();
			return;
		end
		crp = (c == 8'h0D);
		if (!count_line()) return;
		if (c == ":") colon = 1'b1;
	endfunction

	function automatic out_word_t decode_word(in_word_t w);
		out_word_t r;
		bit v;
		v = 1'b0;
		if (w.cmd == CMD_RESTART) start_body();
		else if (w.cmd == CMD_CLOSE) begin
			if (err == ERR_NONE && st == S_EOF) st = S_DONE;
		end else if (w.cmd == CMD_DATA && err == ERR_NONE) begin
			case (st)
				S_FIXED: begin
					v = 1'b1;
					count++;
					if (count >= m_length) st = S_DONE;
				end
				S_EOF: v = 1'b1;
				S_SIZE: size_byte(w.data);
				S_DATA: begin
					v = 1'b1;
					if (remaining != 0) remaining--;
					if (remaining == 0) st = S_DATA_CR;
				end
				S_DATA_CR: begin
					if (w.data == 8'h0D) st = S_DATA_LF;
					else err = ERR_SYNTAX;
				end
				S_DATA_LF: begin
					if (w.data == 8'h0A) begin
						st = S_SIZE;
						clear_line();
					end else err = ERR_SYNTAX;
				end
				S_TRAILER: trailer_byte(w.data);
				default: err = ERR_AFTER;
			endcase
		end
		r.valid = v;
		r.payload = v ? w.data : 8'd0;
		r.done = (st == S_DONE);
		r.err = err;
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending.size() > 0 && (quiet || $urandom_range(0, 9) != 0)) begin
					in_valid <= 1'b1;
					cmd <= pending[0].cmd;
					data_byte <= pending[0].data;
					void'(pending.pop_front());
				end else begin
					in_valid <= 1'b0;
					if (pending.size() > 0) in_gap <= $urandom_range(1, 12);
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 14) == 0) begin
				out_gap <= $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else out_stall <= 1'b0;
		end
	end

	// monitor and predictor
	always @(posedge clk) begin
		out_word_t got, want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) expected_words.push_back(decode_word({cmd, data_byte}));
			if (out_valid && !out_stall) begin
				got = {body_valid, body_byte, message_done, err_status};
				if (expected_words.size() == 0) begin
					$error("unexpected result word");
					failures++;
				end else begin
					want = expected_words.pop_front();
					if (got.valid !== want.valid) begin
						$error("body_valid exp %0d got %0d", want.valid, got.valid);
						failures++;
					end
					if (got.payload !== want.payload) begin
						$error("body_byte exp %0h got %0h", want.payload, got.payload);
						failures++;
					end
					if (got.done !== want.done) begin
						$error("message_done exp %0d got %0d", want.done, got.done);
						failures++;
					end
					if (got.err !== want.err) begin
						$error("err_status exp %0d got %0d", want.err, got.err);
						failures++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic push_word(logic [1:0] c, logic [7:0] d);
		in_word_t w;
		w.cmd = c;
		w.data = d;
		pending.push_back(w);
	endtask

	task automatic push_text(string s);
		foreach (s[i]) push_word(CMD_DATA, s[i]);
	endtask

	task automatic drain();
		while (pending.size() > 0 || expected_words.size() > 0 || in_valid) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MODE) m_mode = val[1:0];
		else m_length = val;
	endtask

	function automatic logic [7:0] pick_byte(int kind);
		string ext_chars;
		ext_chars = "0123456789abcdefABCDEF;= \t\"\\xZ!~";
		case (kind)
			0: return ext_chars[$urandom_range(0, ext_chars.len() - 1)];
			default: return 8'($urandom);
		endcase
	endfunction

	// well formed chunked body with random content, sometimes corrupted
	task automatic push_chunked(bit noisy);
		int n, k, j;
		string s;
		n = $urandom_range(1, 4);
		for (k = 0; k < n; k++) begin
			j = (k == n - 1) ? 0 : $urandom_range(1, 6);
			s = $sformatf("%0h", j);
			if ($urandom_range(0, 2) == 0) s = {" ", s, " "};
			case ($urandom_range(0, 3))
				1: s = {s, ";ab=cd"};
				2: s = {s, "; n = \"q\\\"x\" "};
				3: s = {s, ";tok;x"};
				default: ;
			endcase
			if (j == 0) s = {s, "\r\n"};
			else s = {s, "\r\n"};
			push_text(s);
			repeat (j) push_word(CMD_DATA, 8'($urandom));
			if (j != 0) push_text("\r\n");
			if (noisy && $urandom_range(0, 3) == 0) push_word(CMD_DATA, pick_byte($urandom_range(0, 1)));
		end
		if ($urandom_range(0, 1) == 0) push_text("k: v\r\n");
		if (noisy && $urandom_range(0, 2) == 0) push_text("bad\r\n");
		push_text("\r\n");
		if ($urandom_range(0, 3) == 0) push_word(CMD_DATA, 8'($urandom));
		push_word(CMD_RESTART, 8'($urandom));
	endtask

	initial begin
		int i, k, phase_i;
		m_mode = MODE_FIXED;
		m_length = 0;
		start_body();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: fixed mode, data after end, unused command, EOF mode, chunked size and trailer lines
		push_word(CMD_DATA, 8'hFF);
		push_word(CMD_SPARE, 8'h00);
		push_word(CMD_RESTART, 8'h00);
		drain();
		write_reg(REG_LENGTH, 64'd3);
		push_word(CMD_RESTART, 8'h00);
		push_word(CMD_DATA, 8'h00);
		push_word(CMD_CLOSE, 8'h00);
		push_word(CMD_DATA, 8'hFF);
		push_word(CMD_DATA, 8'h5A);
		push_word(CMD_DATA, 8'hA5);
		drain();
		write_reg(REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_MODE, 64'(MODE_SPARE));
		push_word(CMD_RESTART, 8'h00);
		push_word(CMD_DATA, 8'h11);
		push_word(CMD_CLOSE, 8'h00);
		push_word(CMD_DATA, 8'h22);
		drain();
		write_reg(REG_MODE, 64'(MODE_CHUNKED));
		push_word(CMD_RESTART, 8'h00);
		push_text("11112222333344445\r\n");
		push_word(CMD_RESTART, 8'h00);
		push_text("2\rx\n");
		push_word(CMD_RESTART, 8'h00);
		push_text("1\r\nzX");
		push_word(CMD_RESTART, 8'h00);
		push_text("0\r\nnocolon\r\n");
		push_word(CMD_RESTART, 8'h00);
		push_text("0\r\na\rb:\r\n\r\n");
		drain();

		// random phases across settings
		for (phase_i = 0; phase_i < 8; phase_i++) begin
			if (phase_i == 6) quiet = 1'b1;
			write_reg(REG_MODE, 64'($urandom_range(0, 3)));
			case ($urandom_range(0, 3))
				0: write_reg(REG_LENGTH, 64'd0);
				1: write_reg(REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
				default: write_reg(REG_LENGTH, 64'($urandom_range(1, 12)));
			endcase
			push_word(CMD_RESTART, 8'h00);
			for (i = 0; i < 90; i++) begin
				if (m_mode == MODE_CHUNKED && $urandom_range(0, 3) != 0) begin
					push_chunked($urandom_range(0, 2) == 0);
					i += 15;
				end else begin
					k = $urandom_range(0, 19);
					if (k == 0) push_word(CMD_RESTART, 8'($urandom));
					else if (k == 1) push_word(CMD_CLOSE, 8'($urandom));
					else if (k == 2) push_word(CMD_SPARE, 8'($urandom));
					else push_word(CMD_DATA, pick_byte($urandom_range(0, 1)));
				end
			end
			drain();
		end
		repeat (10) @(posedge clk);
		if (failures == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
